@@ rtl/svle_pkg.sv @@
// Shared types and constants for the square voice with linear envelope.
// Used by svle_ctrl, svle_dp and the top level; depends on nothing.
package svle_pkg;

	localparam int unsigned PeriodW   = 16;
	localparam int unsigned VolumeW   = 15;
	localparam int unsigned LengthW   = 24;
	localparam int unsigned DutyW     = 17;
	localparam int unsigned ProdW     = VolumeW + LengthW;
	localparam int unsigned DivSteps  = VolumeW;
	localparam int unsigned DivCntW   = $clog2(DivSteps);

	localparam logic [DutyW-1:0] DUTY_MAX   = 17'd65536;
	localparam logic [DutyW-1:0] DUTY_RESET = 17'd32768;
	localparam logic [DivCntW-1:0] DIV_LAST = DivCntW'(DivSteps - 1);

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic load_note;
		logic start_tick;
		logic mul;
		logic div_step;
		logic push_out;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/svle_ctrl.sv @@
// Controller state machine of the square voice: sequences load, multiply,
// divide and output handoff. Depends on svle_pkg.
module svle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               action,
	output logic               in_stall,
	input  svle_pkg::stat_t    stat,
	output svle_pkg::cmd_t     cmd
);

	svle_pkg::state_t state_q;
	svle_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			svle_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action == svle_pkg::ACT_LOAD) begin
						cmd.load_note = 1'b1;
					end else begin
						cmd.start_tick = 1'b1;
						state_d = stat.need_div ? svle_pkg::ST_MUL : svle_pkg::ST_WAIT;
					end
				end
			end
			svle_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = svle_pkg::ST_DIV;
			end
			svle_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = svle_pkg::ST_WAIT;
				end
			end
			svle_pkg::ST_WAIT: begin
				if (stat.out_free) begin
					cmd.push_out = 1'b1;
					state_d = svle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = svle_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svle_pkg::ST_DIV && stat.div_done) |=> state_q == svle_pkg::ST_WAIT)
		else $error("divide did not hand over to output stage");

	a_tick_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_tick && stat.need_div) |=> cmd.mul)
		else $error("enveloped tick did not start multiply");
`endif

endmodule

@@ rtl/svle_dp.sv @@
// Datapath of the square voice: note state, duty register, envelope multiply,
// restoring divider and output register. Depends on svle_pkg.
module svle_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [svle_pkg::DutyW-1:0]           cfg_data,
	input  logic [svle_pkg::PeriodW-1:0]         period,
	input  logic [svle_pkg::VolumeW-1:0]         volume,
	input  logic [svle_pkg::LengthW-1:0]         duration,
	input  logic [svle_pkg::LengthW-1:0]         attack,
	input  logic [svle_pkg::LengthW-1:0]         release_req,
	input  svle_pkg::cmd_t                       cmd,
	output svle_pkg::stat_t                      stat,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [svle_pkg::VolumeW-1:0]         sample,
	output logic                                 last,
	output logic                                 active
);

	localparam int unsigned PW = svle_pkg::PeriodW;
	localparam int unsigned VW = svle_pkg::VolumeW;
	localparam int unsigned LW = svle_pkg::LengthW;
	localparam int unsigned DW = svle_pkg::DutyW;
	localparam int unsigned XW = svle_pkg::ProdW;

	logic [DW-1:0]  duty_q;
	logic [PW-1:0]  phase_q;
	logic [LW-1:0]  position_q;
	logic [PW-1:0]  note_period_q;
	logic [PW-1:0]  high_length_q;
	logic [VW-1:0]  note_volume_q;
	logic [LW-1:0]  note_length_q;
	logic [LW-1:0]  attack_q;
	logic [LW-1:0]  release_q;
	logic           playing_q;

	logic [VW-1:0]  wave_q;
	logic [LW-1:0]  num_q;
	logic [LW-1:0]  den_q;
	logic [XW-1:0]  acc_q;
	logic [svle_pkg::DivCntW-1:0] cnt_q;
	logic           res_last_q;
	logic           res_active_q;

	logic           out_valid_q;
	logic [VW-1:0]  sample_q;
	logic           last_q;
	logic           active_q;

	logic [PW-1:0]  p_eff;
	logic [DW-1:0]  d_sat;
	logic [PW+DW-1:0] hl_prod;
	logic [VW-1:0]  wave;
	logic           in_attack;
	logic           in_release;
	logic [LW-1:0]  rel_start;
	logic [LW-1:0]  num;
	logic [LW-1:0]  den;
	logic [LW:0]    pos_inc;
	logic           is_last;
	logic [PW:0]    ph_inc;
	logic           ph_wrap;
	logic [LW:0]    trial;
	logic [LW:0]    diff;
	logic           ge;

	always_comb begin
		p_eff   = (period == '0) ? PW'(1) : period;
		d_sat   = (duty_q > svle_pkg::DUTY_MAX) ? svle_pkg::DUTY_MAX : duty_q;
		hl_prod = {{DW{1'b0}}, p_eff} * {{PW{1'b0}}, d_sat};

		wave       = (phase_q < high_length_q) ? note_volume_q : '0;
		rel_start  = note_length_q - release_q;
		in_attack  = position_q < attack_q;
		in_release = (release_q <= note_length_q) && (position_q > rel_start);
		num        = in_attack ? position_q : (note_length_q - position_q);
		den        = in_attack ? attack_q : release_q;

		pos_inc = {1'b0, position_q} + (LW+1)'(1);
		is_last = pos_inc >= {1'b0, note_length_q};
		ph_inc  = {1'b0, phase_q} + (PW+1)'(1);
		ph_wrap = ph_inc >= {1'b0, note_period_q};

		trial = {acc_q[XW-1:VW], acc_q[VW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};

		stat.need_div = playing_q && (in_attack || in_release) && (wave != '0);
		stat.div_done = cnt_q == svle_pkg::DIV_LAST;
		stat.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q        <= svle_pkg::DUTY_RESET;
			phase_q       <= '0;
			position_q    <= '0;
			note_period_q <= PW'(1);
			high_length_q <= '0;
			note_volume_q <= '0;
			note_length_q <= '0;
			attack_q      <= '0;
			release_q     <= '0;
			playing_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				duty_q <= cfg_data;
			end
			if (cmd.load_note) begin
				note_period_q <= p_eff;
				high_length_q <= hl_prod[PW+15:16];
				note_volume_q <= volume;
				note_length_q <= duration;
				attack_q      <= attack;
				release_q     <= release_req;
				phase_q       <= '0;
				position_q    <= '0;
				playing_q     <= duration != '0;
			end else if (cmd.start_tick && playing_q) begin
				phase_q    <= ph_wrap ? '0 : ph_inc[PW-1:0];
				position_q <= pos_inc[LW-1:0];
				if (is_last) begin
					playing_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + svle_pkg::DivCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_tick) begin
			wave_q       <= wave;
			num_q        <= num;
			den_q        <= den;
			res_last_q   <= playing_q && is_last;
			res_active_q <= playing_q;
			acc_q        <= {{LW{1'b0}}, (playing_q ? wave : VW'(0))};
		end else if (cmd.mul) begin
			acc_q <= {{LW{1'b0}}, wave_q} * {{VW{1'b0}}, num_q};
		end else if (cmd.div_step) begin
			acc_q <= {(ge ? diff[LW-1:0] : trial[LW-1:0]), acc_q[VW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_out) begin
			sample_q <= acc_q[VW-1:0];
			last_q   <= res_last_q;
			active_q <= res_active_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;
	assign active    = active_q;

`ifndef ASSERT_OFF
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < note_period_q)
		else $error("phase outside period");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !active_q) |-> (sample_q == '0 && !last_q))
		else $error("idle request carries a nonzero sample");

	a_play_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(playing_q) |-> ($past(cmd.start_tick) || $past(cmd.load_note)))
		else $error("note ended without a tick or load");
`endif

endmodule

@@ rtl/square_voice_with_linear_envelope_top.sv @@
// Top level of the square voice with linear attack and release envelope.
// Joins svle_ctrl and svle_dp; depends on svle_pkg.
//
// channel   handshake            payload
// in        in_valid / in_stall  action, period, volume, duration, attack, release_req
// out       out_valid/out_stall  sample, last, active
// cfg       cfg_we               cfg_data (duty, Q1.16)
//
// A load updates the note state. A tick outside the ramps skips multiply and divide.
// A tick inside a ramp with the wave high runs one multiply, 15 steps of the
// restoring divider, one quotient bit per cycle, then the handoff to the output register.
// Reset is asynchronous; the voice starts idle with duty at one half.
// The output register holds a result while out_stall is high; the next request is
// still taken and its result waits until the register frees.
module square_voice_with_linear_envelope_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [svle_pkg::DutyW-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [svle_pkg::PeriodW-1:0]         period,
	input  logic [svle_pkg::VolumeW-1:0]         volume,
	input  logic [svle_pkg::LengthW-1:0]         duration,
	input  logic [svle_pkg::LengthW-1:0]         attack,
	input  logic [svle_pkg::LengthW-1:0]         release_req,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [svle_pkg::VolumeW-1:0]         sample,
	output logic                                 last,
	output logic                                 active
);

	svle_pkg::cmd_t  cmd;
	svle_pkg::stat_t stat;

	svle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	svle_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.period      (period),
		.volume      (volume),
		.duration    (duration),
		.attack      (attack),
		.release_req (release_req),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample      (sample),
		.last        (last),
		.active      (active)
	);

endmodule
